FILE: sv/bgc_pkg.sv
package bgc_pkg;

	// Accepted reply length
	localparam logic [7:0] ACCEPT_LEN = 8'd9;

	// Configuration register indexes
	localparam logic REG_FULL_IDLE = 1'b0;
	localparam logic REG_FULL_CHG  = 1'b1;

	localparam logic [9:0] FULL_IDLE_RST = 10'd189;
	localparam logic [9:0] FULL_CHG_RST  = 10'd213;

	// Divider geometry
	localparam int NUM_W = 23;
	localparam int QUO_W = 22;
	localparam int DIV_W = 10;
	localparam int CNT_W = 5;
	localparam logic [CNT_W-1:0] DIV_ITER_CHG  = 5'd8;
	localparam logic [CNT_W-1:0] DIV_ITER_TIME = 5'd22;

	typedef logic [3:0] step_t;

	localparam step_t STEP_IDLE       = 4'd0;
	localparam step_t STEP_FLAGS      = 4'd1;
	localparam step_t STEP_VOLT       = 4'd2;
	localparam step_t STEP_COMP       = 4'd3;
	localparam step_t STEP_SCALE      = 4'd4;
	localparam step_t STEP_DIVLD_CHG  = 4'd5;
	localparam step_t STEP_DIV_CHG    = 4'd6;
	localparam step_t STEP_CHG_FIN    = 4'd7;
	localparam step_t STEP_BOUND      = 4'd8;
	localparam step_t STEP_APPLY      = 4'd9;
	localparam step_t STEP_TSCALE     = 4'd10;
	localparam step_t STEP_DIVLD_TIME = 4'd11;
	localparam step_t STEP_DIV_TIME   = 4'd12;
	localparam step_t STEP_TIME_FIN   = 4'd13;
	localparam step_t STEP_CLEAR      = 4'd14;
	localparam step_t STEP_EMIT       = 4'd15;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_FLAGS,
		OP_VOLT,
		OP_COMP,
		OP_SCALE,
		OP_DIVLD_CHG,
		OP_DIV_STEP,
		OP_CHG_FIN,
		OP_BOUND,
		OP_APPLY_BOUND,
		OP_TSCALE,
		OP_DIVLD_TIME,
		OP_TIME_FIN,
		OP_CLEAR,
		OP_EMIT
	} alu_op_t;

	typedef enum logic [2:0] {
		COND_NEXT,
		COND_JUMP,
		COND_WAIT_IN,
		COND_BADLEN,
		COND_ABSENT,
		COND_DIVLOOP,
		COND_OUT_WAIT
	} cond_t;

	typedef struct packed {
		alu_op_t op;
		cond_t   cond;
		step_t   target;
	} ucode_t;

	typedef struct packed {
		logic load;
		logic mode_chg;
		logic step;
	} div_ctrl_t;

	typedef struct packed {
		logic [7:0]  reply_length;
		logic        ac_present;
		logic        batt_present;
		logic        charging;
		logic        full_req;
		logic        pcharge_reset;
		logic [7:0]  cpu_temp_raw;
		logic [15:0] voltage_raw;
		logic [7:0]  batt_temp_raw;
		logic [7:0]  current_raw;
		logic [15:0] used_charge_raw;
	} in_word_t;

	typedef struct packed {
		logic        status;
		logic        ac_flag;
		logic        present_flag;
		logic        charging_flag;
		logic        discharging_flag;
		logic        full_flag;
		logic [28:0] cpu_temp_uk;
		logic [28:0] batt_temp_uk;
		logic [30:0] voltage_uv;
		logic [17:0] current_ua;
		logic [7:0]  charge_pct;
		logic [21:0] time_min;
	} out_word_t;

	// Microprogram: one control word per step
	function automatic ucode_t ucode_rom(input step_t step);
		ucode_t w;
		w = '{op: OP_NOP, cond: COND_NEXT, target: STEP_IDLE};
		unique case (step)
			STEP_IDLE:       w = '{op: OP_NOP,        cond: COND_WAIT_IN,  target: STEP_FLAGS};
			STEP_FLAGS:      w = '{op: OP_FLAGS,      cond: COND_BADLEN,   target: STEP_EMIT};
			STEP_VOLT:       w = '{op: OP_VOLT,       cond: COND_ABSENT,   target: STEP_CLEAR};
			STEP_COMP:       w = '{op: OP_COMP,       cond: COND_NEXT,     target: STEP_IDLE};
			STEP_SCALE:      w = '{op: OP_SCALE,      cond: COND_NEXT,     target: STEP_IDLE};
			STEP_DIVLD_CHG:  w = '{op: OP_DIVLD_CHG,  cond: COND_NEXT,     target: STEP_IDLE};
			STEP_DIV_CHG:    w = '{op: OP_DIV_STEP,   cond: COND_DIVLOOP,  target: STEP_IDLE};
			STEP_CHG_FIN:    w = '{op: OP_CHG_FIN,    cond: COND_NEXT,     target: STEP_IDLE};
			STEP_BOUND:      w = '{op: OP_BOUND,      cond: COND_NEXT,     target: STEP_IDLE};
			STEP_APPLY:      w = '{op: OP_APPLY_BOUND, cond: COND_NEXT,    target: STEP_IDLE};
			STEP_TSCALE:     w = '{op: OP_TSCALE,     cond: COND_NEXT,     target: STEP_IDLE};
			STEP_DIVLD_TIME: w = '{op: OP_DIVLD_TIME, cond: COND_NEXT,     target: STEP_IDLE};
			STEP_DIV_TIME:   w = '{op: OP_DIV_STEP,   cond: COND_DIVLOOP,  target: STEP_IDLE};
			STEP_TIME_FIN:   w = '{op: OP_TIME_FIN,   cond: COND_JUMP,     target: STEP_EMIT};
			STEP_CLEAR:      w = '{op: OP_CLEAR,      cond: COND_NEXT,     target: STEP_IDLE};
			STEP_EMIT:       w = '{op: OP_EMIT,       cond: COND_OUT_WAIT, target: STEP_IDLE};
			default:         w = '{op: OP_NOP,        cond: COND_JUMP,     target: STEP_IDLE};
		endcase
		return w;
	endfunction

endpackage

FILE: sv/bgc_div.sv
// Restoring divider, one quotient bit per cycle while ctrl.step is high.
// Charge mode: upper dividend bits preload the remainder, 8 steps.
// Time mode: low 22 dividend bits shifted through, 22 steps.
module bgc_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bgc_pkg::div_ctrl_t        ctrl,
	input  logic [bgc_pkg::NUM_W-1:0] dividend,
	input  logic [bgc_pkg::DIV_W-1:0] divisor,
	output logic [bgc_pkg::QUO_W-1:0] quotient,
	output logic                      last
);

	logic [bgc_pkg::DIV_W-1:0] rem_q;
	logic [bgc_pkg::QUO_W-1:0] quo_q;
	logic [bgc_pkg::DIV_W-1:0] dsr_q;
	logic [bgc_pkg::CNT_W-1:0] cnt_q;

	logic [bgc_pkg::DIV_W:0] rem_sh;
	logic [bgc_pkg::DIV_W:0] rem_sub;
	logic                    ge;

	assign rem_sh  = {rem_q, quo_q[bgc_pkg::QUO_W-1]};
	assign ge      = rem_sh >= {1'b0, dsr_q};
	assign rem_sub = rem_sh - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctrl.load) begin
			cnt_q <= ctrl.mode_chg ? bgc_pkg::DIV_ITER_CHG : bgc_pkg::DIV_ITER_TIME;
		end else if (ctrl.step) begin
			cnt_q <= cnt_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			dsr_q <= divisor;
			if (ctrl.mode_chg) begin
				rem_q <= dividend[17:8];
				quo_q <= {dividend[7:0], 14'd0};
			end else begin
				rem_q <= '0;
				quo_q <= dividend[bgc_pkg::QUO_W-1:0];
			end
		end else if (ctrl.step) begin
			rem_q <= ge ? rem_sub[bgc_pkg::DIV_W-1:0] : rem_sh[bgc_pkg::DIV_W-1:0];
			quo_q <= {quo_q[bgc_pkg::QUO_W-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign last     = (cnt_q == 5'd1);

endmodule

FILE: sv/battery_gauge_calc_unit.sv
// Battery gauge calculator for one decoded power-controller reply.
//
// Channels: item (input words, valid/stall), result (output words,
// valid/stall) and a configuration write port (valid/ready, index, data)
// for the two full-voltage registers. Configuration is always ready; write
// it only while no reply is in flight.
// Each accepted item gives exactly one result word. A reply of length 9
// updates the held gauge values; any other length keeps them and reports
// status 1. Apart from the status, the result is built from the held values.
// The result word is registered at the emit step, reached after the
// full computation for a good reply with the battery present, after the
// clear step for an absent battery and straight from the flags step for a
// bad length. The block takes one reply at a time; the item channel opens
// in the same cycle the result word appears. The computation uses the shared
// one-bit-per-cycle divider: 8 steps for the charge percent and 22 for the
// remaining minutes, driven by a 16-step microprogram.
// Reset clears the held values to zero, the registers to 189 and 213, and
// returns the sequencer to idle. While the receiver stalls the result word
// holds; the next reply may still be computed and waits at the last step
// until the output register frees up.
module battery_gauge_calc_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  bgc_pkg::in_word_t   item,
	output logic                result_valid,
	input  logic                result_stall,
	output bgc_pkg::out_word_t  result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [9:0]          cfg_data
);

	// Sequencer
	bgc_pkg::step_t     pc_q;
	bgc_pkg::step_t     pc_d;
	bgc_pkg::ucode_t    uw;

	// Configuration
	logic [9:0]         full_idle_q;
	logic [9:0]         full_chg_q;

	// Latched reply and working registers
	bgc_pkg::in_word_t  item_q;
	logic               bad_q;
	logic [16:0]        vb_q;
	logic [22:0]        num_q;
	logic               ovf_q;
	logic [7:0]         charge_q;
	logic [6:0]         bound_q;

	// Held gauge state
	logic [4:0]         held_flags_q;
	logic [7:0]         held_cpu_temp_q;
	logic [7:0]         held_batt_temp_q;
	logic [20:0]        held_voltage_q;
	logic [7:0]         held_current_q;
	logic [7:0]         held_charge_q;
	logic [21:0]        held_time_q;

	// Output register
	bgc_pkg::out_word_t result_q;
	logic               result_valid_q;

	// Datapath nets
	logic               accept;
	logic               len_ok;
	logic               out_free;
	logic               emit_load;
	logic               div_last;
	logic [21:0]        div_quo;
	bgc_pkg::div_ctrl_t div_ctrl;
	logic [9:0]         vmax;
	logic [21:0]        volt_sum;
	logic [5:0]         cur_over;
	logic [7:0]         comp_m;
	logic [15:0]        comp_prod;
	logic [3:0]         comp;
	logic [12:0]        used_clip;
	logic [24:0]        used_prod;
	logic [6:0]         used_quo;
	logic [9:0]         div_dsr;
	logic [28:0]        cpu_uk;
	logic [28:0]        batt_uk;
	logic [30:0]        volt_uv;
	logic [17:0]        cur_ua;

	assign uw         = bgc_pkg::ucode_rom(pc_q);
	assign item_stall = (pc_q != bgc_pkg::STEP_IDLE);
	assign accept     = item_valid && !item_stall;
	assign len_ok     = (item_q.reply_length == bgc_pkg::ACCEPT_LEN);
	assign out_free   = !result_valid_q || !result_stall;
	assign emit_load  = (uw.op == bgc_pkg::OP_EMIT) && out_free;
	assign cfg_ready  = 1'b1;

	// Full-voltage register follows the held mains flag
	assign vmax = held_flags_q[0] ? full_chg_q : full_idle_q;

	// (raw*265 + 72665)/10 == (raw*53 + 14533) >> 1 exactly
	assign volt_sum = 22'({6'd0, item_q.voltage_raw} * 22'd53) + 22'd14533;

	// Load compensation: (cur-200)*15/100 == (3*(cur-200))/20, by reciprocal 205/4096
	assign cur_over  = 6'(item_q.current_raw - 8'd200);
	assign comp_m    = 8'({2'd0, cur_over} * 8'd3);
	assign comp_prod = 16'({8'd0, comp_m} * 16'd205);
	assign comp      = comp_prod[15:12];

	// Coulomb bound: min(used,6500)/65 by reciprocal 4033/2^18
	assign used_clip = (item_q.used_charge_raw > 16'd6500) ? 13'd6500
	                                                       : item_q.used_charge_raw[12:0];
	assign used_prod = 25'({12'd0, used_clip} * 25'd4033);
	assign used_quo  = used_prod[24:18];

	assign div_dsr = (uw.op == bgc_pkg::OP_DIVLD_CHG) ? vmax : {2'd0, item_q.current_raw};

	always_comb begin
		div_ctrl          = '0;
		div_ctrl.load     = (uw.op == bgc_pkg::OP_DIVLD_CHG) || (uw.op == bgc_pkg::OP_DIVLD_TIME);
		div_ctrl.mode_chg = (uw.op == bgc_pkg::OP_DIVLD_CHG);
		div_ctrl.step     = (uw.op == bgc_pkg::OP_DIV_STEP);
	end

	bgc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (div_ctrl),
		.dividend (num_q),
		.divisor  (div_dsr),
		.quotient (div_quo),
		.last     (div_last)
	);

	// Next step
	always_comb begin
		pc_d = pc_q;
		unique case (uw.cond)
			bgc_pkg::COND_NEXT:     pc_d = 4'(pc_q + 4'd1);
			bgc_pkg::COND_JUMP:     pc_d = uw.target;
			bgc_pkg::COND_WAIT_IN:  pc_d = item_valid ? uw.target : pc_q;
			bgc_pkg::COND_BADLEN:   pc_d = len_ok ? 4'(pc_q + 4'd1) : uw.target;
			bgc_pkg::COND_ABSENT:   pc_d = item_q.batt_present ? 4'(pc_q + 4'd1) : uw.target;
			bgc_pkg::COND_DIVLOOP:  pc_d = div_last ? 4'(pc_q + 4'd1) : pc_q;
			bgc_pkg::COND_OUT_WAIT: pc_d = out_free ? uw.target : pc_q;
			default:                pc_d = bgc_pkg::STEP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= bgc_pkg::STEP_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_idle_q <= bgc_pkg::FULL_IDLE_RST;
			full_chg_q  <= bgc_pkg::FULL_CHG_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				bgc_pkg::REG_FULL_IDLE: full_idle_q <= cfg_data;
				bgc_pkg::REG_FULL_CHG:  full_chg_q  <= cfg_data;
				default:                full_idle_q <= full_idle_q;
			endcase
		end
	end

	// Latch the reply word and run the working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
		case (uw.op)
			bgc_pkg::OP_FLAGS:      bad_q <= !len_ok;
			bgc_pkg::OP_COMP: begin
				vb_q <= {1'b0, item_q.voltage_raw} +
				        ((!held_flags_q[0] && item_q.current_raw > 8'd200) ? {13'd0, comp}
				                                                            : 17'd0);
			end
			bgc_pkg::OP_SCALE:      num_q <= 23'({6'd0, vb_q} * 23'd100);
			bgc_pkg::OP_DIVLD_CHG:  ovf_q <= num_q >= {5'd0, vmax, 8'd0};
			bgc_pkg::OP_CHG_FIN:    charge_q <= ovf_q ? 8'd255 : div_quo[7:0];
			bgc_pkg::OP_BOUND:      bound_q <= 7'd100 - used_quo;
			bgc_pkg::OP_APPLY_BOUND: begin
				if (held_flags_q[4] && ({1'b0, bound_q} < charge_q)) begin
					charge_q <= {1'b0, bound_q};
				end
			end
			bgc_pkg::OP_TSCALE:     num_q <= 23'({15'd0, charge_q} * 23'd16440);
			default:                bad_q <= bad_q;
		endcase
	end

	// Held gauge state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_flags_q     <= '0;
			held_cpu_temp_q  <= '0;
			held_batt_temp_q <= '0;
			held_voltage_q   <= '0;
			held_current_q   <= '0;
			held_charge_q    <= '0;
			held_time_q      <= '0;
		end else begin
			case (uw.op)
				bgc_pkg::OP_FLAGS: begin
					if (len_ok) begin
						held_flags_q    <= {item_q.pcharge_reset, item_q.full_req,
						                    item_q.charging, item_q.batt_present,
						                    item_q.ac_present};
						held_cpu_temp_q <= item_q.cpu_temp_raw;
					end
				end
				bgc_pkg::OP_VOLT: begin
					held_voltage_q   <= volt_sum[21:1];
					held_current_q   <= item_q.current_raw;
					held_batt_temp_q <= item_q.batt_temp_raw;
				end
				bgc_pkg::OP_TIME_FIN: begin
					held_charge_q <= charge_q;
					held_time_q   <= (item_q.current_raw == 8'd0) ? 22'd0 : div_quo;
				end
				bgc_pkg::OP_CLEAR: begin
					held_voltage_q   <= '0;
					held_current_q   <= '0;
					held_batt_temp_q <= '0;
					held_charge_q    <= '0;
					held_time_q      <= '0;
				end
				default: held_flags_q <= held_flags_q;
			endcase
		end
	end

	// Scale the held values for the result word
	assign cpu_uk  = 29'({21'd0, held_cpu_temp_q} * 29'd1000000) + 29'd273150000;
	assign batt_uk = 29'({21'd0, held_batt_temp_q} * 29'd1000000) + 29'd273150000;
	assign volt_uv = 31'({10'd0, held_voltage_q} * 31'd1000);
	assign cur_ua  = 18'({10'd0, held_current_q} * 18'd1000);

	// Output register: load on the last step, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (emit_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			result_q.status           <= bad_q;
			result_q.ac_flag          <= held_flags_q[0];
			result_q.present_flag     <= held_flags_q[1];
			result_q.charging_flag    <= held_flags_q[2];
			result_q.discharging_flag <= !held_flags_q[2] && !held_flags_q[0];
			result_q.full_flag        <= held_flags_q[3];
			result_q.cpu_temp_uk      <= cpu_uk;
			result_q.batt_temp_uk     <= batt_uk;
			result_q.voltage_uv       <= volt_uv;
			result_q.current_ua       <= cur_ua;
			result_q.charge_pct       <= held_charge_q;
			result_q.time_min         <= held_time_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// A taken reply word blocks the item channel on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> item_stall)
		else $error("item channel open right after a reply word was taken");

	// A result appears only from the last microprogram step
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(pc_q) == bgc_pkg::STEP_EMIT)
		else $error("result word raised outside the emit step");

	// At the emit step, remaining time is zero whenever the held current is zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == bgc_pkg::STEP_EMIT) && (held_time_q != 22'd0) |-> held_current_q != 8'd0)
		else $error("remaining time held with zero current");

endmodule
